[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros for the generation member index generator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check on every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/gmig_pkg.sv]
// ----------------------------------------------------------------------------
// gmig_pkg
// Types and constants shared by the generation member index generator.
// ----------------------------------------------------------------------------
package gmig_pkg;

    localparam int GID_W   = 16;
    localparam int SIZE_W  = 7;
    localparam int CNT_W   = 17;
    localparam int PKT_W   = 16;
    localparam int SLOT_W  = 6;
    localparam int PROD_W  = GID_W + SIZE_W;
    localparam int X_W     = 25;
    localparam int RAW_W   = X_W + 1;
    localparam int ST_W    = CNT_W + 2;

    localparam int unsigned BORROW_STEP = 7;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SIZE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GEN_SIZE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_PACKETS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_GENS    = 3'd4;

    localparam logic MODE_RANDOM = 1'b0;
    localparam logic MODE_BAND   = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_ERR,
        S_MUL,
        S_LEAD,
        S_BASE_GO,
        S_BASE_WAIT,
        S_ROT_GO,
        S_ROT_WAIT,
        S_CAND,
        S_BOR,
        S_BMUL,
        S_RAW_GO,
        S_RAW_WAIT,
        S_SCAN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic              mode;
        logic [SIZE_W-1:0] base_size;
        logic [SIZE_W-1:0] gen_size;
        logic [CNT_W-1:0]  num_packets;
        logic [CNT_W-1:0]  num_gens;
    } t_cfg;

    typedef struct packed {
        logic [PKT_W-1:0]  packet_index;
        logic [SLOT_W-1:0] slot;
        logic [GID_W-1:0]  generation;
        logic              last;
        logic              bad_request;
    } t_res;

    typedef struct packed {
        logic push;
        t_res res;
    } t_out;

    typedef struct packed {
        logic             start;
        logic [X_W-1:0]   x;
        logic [CNT_W-1:0] m;
    } t_mod_req;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] rem;
    } t_mod_rsp;

endpackage

[rtl/gmig_req_if.sv]
// ----------------------------------------------------------------------------
// gmig_req_if
// Request channel: one generation number per word.
// ----------------------------------------------------------------------------
interface gmig_req_if import gmig_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [GID_W-1:0] gen_id;

    modport source (output valid, output gen_id, input ready);
    modport sink   (input valid, input gen_id, output ready);

endinterface

[rtl/gmig_res_if.sv]
// ----------------------------------------------------------------------------
// gmig_res_if
// Result channel: one member packet index per word.
// ----------------------------------------------------------------------------
interface gmig_res_if import gmig_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [PKT_W-1:0]  packet_index;
    logic [SLOT_W-1:0] slot;
    logic [GID_W-1:0]  generation;
    logic              last;
    logic              bad_request;

    modport source (
        output valid, output packet_index, output slot, output generation,
        output last, output bad_request, input ready
    );
    modport sink (
        input valid, input packet_index, input slot, input generation,
        input last, input bad_request, output ready
    );

endinterface

[rtl/gmig_divmod.sv]
// ----------------------------------------------------------------------------
// gmig_divmod
// Restoring remainder unit: x mod m, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module gmig_divmod import gmig_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mod_req i_req,
    output t_mod_rsp o_rsp
);

    localparam int CW = $clog2(X_W);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [X_W-1:0]   r_x;
    logic [CNT_W-1:0] r_m;
    logic [CNT_W-1:0] r_rem;

    logic [CNT_W:0]   trial;
    logic             trial_ge;
    logic [CNT_W-1:0] n_rem;

    always_comb begin
        trial    = {r_rem, r_x[X_W-1]};
        trial_ge = trial >= {1'b0, r_m};
        n_rem    = trial_ge ? CNT_W'(trial - {1'b0, r_m}) : CNT_W'(trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(X_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x   <= i_req.x;
            r_m   <= i_req.m;
            r_rem <= '0;
        end else if (r_busy) begin
            r_x   <= {r_x[X_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

[rtl/gmig_seq.sv]
// ----------------------------------------------------------------------------
// gmig_seq
// Member sequencer: builds each candidate index, scans the member memory for
// collisions, bumps on a hit, writes the member back and emits it; a bad request gets an error word.
// ----------------------------------------------------------------------------
module gmig_seq import gmig_pkg::*; #(
    parameter int MAX_GEN_SIZE = 64,
    parameter int INDEX_BITS   = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    gmig_req_if.sink        i_req,
    input  t_cfg            i_cfg,
    input  logic            i_out_free,
    output t_out            o_out,
    output t_mod_req        o_mod_req,
    input  t_mod_rsp        i_mod_rsp
);

    localparam int AW = $clog2(MAX_GEN_SIZE);
    localparam int IW = INDEX_BITS;
    localparam int PW = (INDEX_BITS + 1 > CNT_W) ? INDEX_BITS + 1 : CNT_W;
    localparam logic [SIZE_W+1:0] MAX_G = (SIZE_W + 2)'(MAX_GEN_SIZE);
    localparam logic [PW-1:0]     P_MAX = PW'(1) << INDEX_BITS;

    t_state r_state, n_state;

    logic [GID_W-1:0]        r_gid;
    logic [SIZE_W-1:0]       r_j;
    logic [SIZE_W-1:0]       r_rot;
    logic [SIZE_W-1:0]       r_sec;
    logic [SIZE_W-1:0]       r_clean;
    logic [SIZE_W-1:0]       r_rd;
    logic                    r_chk;
    logic                    r_neg;
    logic [CNT_W-1:0]        r_idx;
    logic [CNT_W-1:0]        r_base;
    logic [PROD_W-1:0]       r_prod;
    logic signed [ST_W-1:0]  r_start;
    logic signed [RAW_W-1:0] r_raw;
    logic [IW-1:0]           r_rd_data;
    logic [IW-1:0]           mem [MAX_GEN_SIZE];

    logic                    bad;
    logic [CNT_W-1:0]        p_minus_g;
    logic [CNT_W-1:0]        lead;
    logic [SIZE_W:0]         off;
    logic [SIZE_W:0]         sec_sum;
    logic [SIZE_W-1:0]       sec;
    logic signed [ST_W-1:0]  st0, st1, st2;
    logic [X_W-1:0]          raw_mag;
    logic [CNT_W-1:0]        raw_fix;
    logic                    hit;
    logic [CNT_W-1:0]        idx_inc;
    logic [CNT_W-1:0]        base_inc;
    logic [SIZE_W-1:0]       n_clean;
    logic [SIZE_W-1:0]       n_rd;
    logic                    scan_done;
    logic                    is_last;
    logic                    mem_we;

    // datapath
    always_comb begin
        bad = ({1'b0, r_gid} >= i_cfg.num_gens)
            || (i_cfg.base_size == '0)
            || (i_cfg.gen_size == '0)
            || ((SIZE_W + 2)'(i_cfg.gen_size) > MAX_G)
            || (i_cfg.base_size > i_cfg.gen_size)
            || (CNT_W'(i_cfg.gen_size) > i_cfg.num_packets)
            || (PW'(i_cfg.num_packets) > P_MAX);

        p_minus_g = i_cfg.num_packets - CNT_W'(i_cfg.gen_size);
        lead      = (r_prod > PROD_W'(p_minus_g)) ? p_minus_g : CNT_W'(r_prod);

        off = (SIZE_W + 1)'(r_j) - (SIZE_W + 1)'(i_cfg.base_size)
            + (SIZE_W + 1)'(BORROW_STEP);
        sec_sum = (SIZE_W + 1)'(r_j) - (SIZE_W + 1)'(i_cfg.base_size)
                + (SIZE_W + 1)'(r_rot);
        if (sec_sum >= (SIZE_W + 1)'(i_cfg.gen_size)) begin
            sec = SIZE_W'(sec_sum - (SIZE_W + 1)'(i_cfg.gen_size));
        end else begin
            sec = SIZE_W'(sec_sum);
        end

        st0 = $signed(ST_W'(r_gid)) - $signed(ST_W'(off));
        st1 = st0[ST_W-1] ? st0 + $signed(ST_W'(i_cfg.num_gens)) : st0;
        st2 = (st1 == $signed(ST_W'(r_gid))) ? st1 + $signed(ST_W'(1)) : st1;

        raw_mag = r_raw[RAW_W-1] ? X_W'(-r_raw) : X_W'(r_raw);
        raw_fix = (r_neg && (i_mod_rsp.rem != '0))
                ? i_cfg.num_packets - i_mod_rsp.rem : i_mod_rsp.rem;

        hit     = r_chk && (r_rd_data == IW'(r_idx));
        idx_inc = (r_idx + CNT_W'(1) == i_cfg.num_packets) ? '0 : r_idx + CNT_W'(1);
        base_inc = (r_base + CNT_W'(1) == i_cfg.num_packets) ? '0 : r_base + CNT_W'(1);
        n_clean = hit ? SIZE_W'(1) : r_clean + SIZE_W'(1);
        n_rd    = (r_rd + SIZE_W'(1) == r_j) ? '0 : r_rd + SIZE_W'(1);
        scan_done = (r_j == '0) || (r_chk && (n_clean == r_j));
        is_last   = (r_j + SIZE_W'(1) == i_cfg.gen_size);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_req.valid) n_state = S_CHECK;
            S_CHECK:     n_state = bad ? S_ERR : S_MUL;
            S_ERR:       if (i_out_free) n_state = S_IDLE;
            S_MUL:       n_state = (i_cfg.mode == MODE_BAND) ? S_LEAD : S_BASE_GO;
            S_LEAD:      n_state = S_CAND;
            S_BASE_GO:   n_state = S_BASE_WAIT;
            S_BASE_WAIT: if (i_mod_rsp.done) n_state = S_ROT_GO;
            S_ROT_GO:    n_state = S_ROT_WAIT;
            S_ROT_WAIT:  if (i_mod_rsp.done) n_state = S_CAND;
            S_CAND: begin
                if (i_cfg.mode == MODE_BAND || r_j < i_cfg.base_size) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_BOR;
                end
            end
            S_BOR:       n_state = S_BMUL;
            S_BMUL:      n_state = S_RAW_GO;
            S_RAW_GO:    n_state = S_RAW_WAIT;
            S_RAW_WAIT:  if (i_mod_rsp.done) n_state = S_SCAN;
            S_SCAN:      if (scan_done) n_state = S_EMIT;
            S_EMIT: begin
                if (i_out_free) n_state = is_last ? S_IDLE : S_CAND;
            end
            default:     n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        i_req.ready = 1'b0;
        o_mod_req   = '0;
        o_out       = '0;
        mem_we      = 1'b0;
        unique case (r_state)
            S_IDLE: i_req.ready = 1'b1;
            S_ERR: begin
                o_out.push                = i_out_free;
                o_out.res.generation      = r_gid;
                o_out.res.last            = 1'b1;
                o_out.res.bad_request     = 1'b1;
            end
            S_BASE_GO: begin
                o_mod_req.start = 1'b1;
                o_mod_req.x     = X_W'(r_prod);
                o_mod_req.m     = i_cfg.num_packets;
            end
            S_ROT_GO: begin
                o_mod_req.start = 1'b1;
                o_mod_req.x     = X_W'(r_gid) * X_W'(BORROW_STEP);
                o_mod_req.m     = CNT_W'(i_cfg.gen_size);
            end
            S_RAW_GO: begin
                o_mod_req.start = 1'b1;
                o_mod_req.x     = raw_mag;
                o_mod_req.m     = i_cfg.num_packets;
            end
            S_EMIT: begin
                o_out.push             = i_out_free;
                mem_we                 = i_out_free;
                o_out.res.packet_index = PKT_W'(r_idx);
                o_out.res.slot         = SLOT_W'(r_j);
                o_out.res.generation   = r_gid;
                o_out.res.last         = is_last;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // scan control: restart from entry zero on every entry to the scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || r_state != S_SCAN) begin
            r_rd    <= '0;
            r_chk   <= 1'b0;
            r_clean <= '0;
        end else begin
            r_rd  <= n_rd;
            r_chk <= 1'b1;
            if (r_chk) r_clean <= n_clean;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE:      if (i_req.valid) r_gid <= i_req.gen_id;
            S_CHECK:     r_j <= '0;
            S_MUL:       r_prod <= PROD_W'(r_gid) * PROD_W'(i_cfg.base_size);
            S_LEAD:      r_base <= lead;
            S_BASE_WAIT: if (i_mod_rsp.done) r_base <= i_mod_rsp.rem;
            S_ROT_WAIT:  if (i_mod_rsp.done) r_rot <= SIZE_W'(i_mod_rsp.rem);
            S_CAND:      r_idx <= r_base;
            S_BOR: begin
                r_start <= st2;
                r_sec   <= sec;
            end
            S_BMUL: begin
                r_raw <= r_start * $signed({1'b0, i_cfg.base_size})
                       + $signed(RAW_W'(r_sec));
            end
            S_RAW_GO:    r_neg <= r_raw[RAW_W-1];
            S_RAW_WAIT:  if (i_mod_rsp.done) r_idx <= raw_fix;
            S_SCAN:      if (hit) r_idx <= idx_inc;
            S_EMIT: begin
                if (i_out_free) begin
                    r_j    <= r_j + SIZE_W'(1);
                    r_base <= base_inc;
                end
            end
            default: ;
        endcase
    end

    // member memory
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[AW'(r_j)] <= IW'(r_idx);
        r_rd_data <= mem[AW'(r_rd)];
    end

endmodule

[rtl/generation_member_index_generator_core.sv]
// ----------------------------------------------------------------------------
// generation_member_index_generator_core
// Emits the member packet indices of a requested generation, in slot order.
// ----------------------------------------------------------------------------
// Flow: an error word passes S_CHECK and S_ERR into the output word register; band
//   mode takes the first base from S_MUL and S_LEAD, random mode from two setup
//   remainders, and each borrowed slot needs one more, all from the remainder unit.
// Requests: one at a time; each slot scans its earlier members again after every
//   collision bump, and a word is emitted only while the output word register is free.
// Reset: synchronous, active low; config mode 0, other config fields 1, no memory clear.
module generation_member_index_generator_core import gmig_pkg::*; #(
    parameter int MAX_GEN_SIZE = 64,
    parameter int INDEX_BITS   = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    gmig_req_if.sink             i_req,
    gmig_res_if.source           o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CNT_W-1:0]     i_cfg_data
);

    t_cfg     r_cfg;
    logic     r_out_valid;
    t_res     r_out;
    t_out     seq_out;
    t_mod_req mod_req;
    t_mod_rsp mod_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode        <= MODE_RANDOM;
            r_cfg.base_size   <= SIZE_W'(1);
            r_cfg.gen_size    <= SIZE_W'(1);
            r_cfg.num_packets <= CNT_W'(1);
            r_cfg.num_gens    <= CNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:        r_cfg.mode        <= i_cfg_data[0];
                CFG_BASE_SIZE:   r_cfg.base_size   <= i_cfg_data[SIZE_W-1:0];
                CFG_GEN_SIZE:    r_cfg.gen_size    <= i_cfg_data[SIZE_W-1:0];
                CFG_NUM_PACKETS: r_cfg.num_packets <= i_cfg_data;
                CFG_NUM_GENS:    r_cfg.num_gens    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    gmig_seq #(
        .MAX_GEN_SIZE (MAX_GEN_SIZE),
        .INDEX_BITS   (INDEX_BITS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cfg      (r_cfg),
        .i_out_free (!r_out_valid),
        .o_out      (seq_out),
        .o_mod_req  (mod_req),
        .i_mod_rsp  (mod_rsp)
    );

    gmig_divmod u_divmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_out.push) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_out.push) r_out <= seq_out.res;
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.packet_index = r_out.packet_index;
    assign o_res.slot         = r_out.slot;
    assign o_res.generation   = r_out.generation;
    assign o_res.last         = r_out.last;
    assign o_res.bad_request  = r_out.bad_request;

`include "assert_macros.svh"

    `ASSERT_CLK(a_push_into_free,
        seq_out.push |=> r_out_valid && !$past(r_out_valid),
        "word pushed over a held word")
    `ASSERT_CLK(a_err_word,
        o_res.valid && o_res.bad_request |->
            o_res.last && o_res.slot == '0 && o_res.packet_index == '0,
        "malformed error word")
    `ASSERT_CLK(a_index_range,
        o_res.valid && !o_res.bad_request |->
            CNT_W'(o_res.packet_index) < r_cfg.num_packets,
        "member index beyond packet count")
    `ASSERT_CLK(a_last_slot,
        o_res.valid && o_res.last && !o_res.bad_request |->
            o_res.slot == SLOT_W'(r_cfg.gen_size - SIZE_W'(1)),
        "last mark off the final slot")

endmodule
